### src/gnt_pkg.sv
// gnt_pkg: shared types, constants and angle tables for the gauge needle tip block
// no dependencies; imported by every module under src
`timescale 1ns / 1ps

package gnt_pkg;

  // clip limit and trig precision
  localparam int CLIP_LIMIT_TENTHS  = 600;
  localparam int TRIG_FRACTION_BITS = 16;

  // field widths
  localparam int ANGLE_W = 16;
  localparam int CX_W    = 10;
  localparam int CY_W    = 10;
  localparam int RAD_W   = 9;
  localparam int TIPX_W  = 12;
  localparam int TIPY_W  = 11;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_RADIUS = 2'd2;

  // clamped angle magnitude, split into a high and a low part for the turn tables
  localparam int LO_W  = 4;
  localparam int MAG_W = ($clog2(CLIP_LIMIT_TENTHS + 1) > LO_W) ?
                         $clog2(CLIP_LIMIT_TENTHS + 1) : LO_W + 1;
  localparam int HI_W  = MAG_W - LO_W;

  // tenths of a degree per full turn
  localparam int TURN_DIV  = 3600;
  localparam int TURN_HALF = 1800;
  localparam int R_W       = $clog2(TURN_DIV);

  // binary angle, 2^32 units per turn
  localparam int Z_W  = 32;
  localparam int ZM_W = Z_W - 1;

  // cordic datapath
  localparam int ITER_N  = TRIG_FRACTION_BITS;
  localparam int SHIFT_W = $clog2(ITER_N);
  localparam int XY_W    = TRIG_FRACTION_BITS + 3;

  localparam logic [63:0] GAIN_Q32 = 64'h9B74EDA8;
  localparam logic [XY_W-1:0] X_START =
    XY_W'((GAIN_Q32 + (64'd1 << (31 - TRIG_FRACTION_BITS))) >> (32 - TRIG_FRACTION_BITS));

  // atan(2^-i) in binary angle units
  localparam int ATAN_N = 28;
  localparam logic [Z_W-1:0] ATAN_TAB [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  // output scaling
  localparam int PROD_W = XY_W + RAD_W;
  localparam int RND_W  = PROD_W + 1 - TRIG_FRACTION_BITS;
  localparam int SUM_W  = RND_W + 2;

  typedef logic [ZM_W-1:0] zmag_t;

  // quotient and remainder of a part of the angle times 2^32 over one turn
  typedef struct packed {
    zmag_t          q;
    logic [R_W-1:0] r;
  } turn_ent_t;

  typedef turn_ent_t [(1 << HI_W)-1:0] hi_tab_t;
  typedef turn_ent_t [(1 << LO_W)-1:0] lo_tab_t;

  function automatic hi_tab_t build_hi_tab();
    hi_tab_t         t;
    longint unsigned num;
    for (int h = 0; h < (1 << HI_W); h++) begin
      num    = longint'(h) << (LO_W + 32);
      t[h].q = ZM_W'(num / TURN_DIV);
      t[h].r = R_W'(num % TURN_DIV);
    end
    return t;
  endfunction

  function automatic lo_tab_t build_lo_tab();
    lo_tab_t         t;
    longint unsigned num;
    for (int l = 0; l < (1 << LO_W); l++) begin
      num    = longint'(l) << 32;
      t[l].q = ZM_W'(num / TURN_DIV);
      t[l].r = R_W'(num % TURN_DIV);
    end
    return t;
  endfunction

  localparam hi_tab_t HI_TAB = build_hi_tab();
  localparam lo_tab_t LO_TAB = build_lo_tab();

  // vector handed from cell to cell
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_vec_t;

  // configuration seen by the output stages
  typedef struct packed {
    logic [CX_W-1:0]  centre_x;
    logic [CY_W-1:0]  centre_y;
    logic [RAD_W-1:0] needle_radius;
  } tip_cfg_t;

endpackage

### src/gnt_angle_prep.sv
// gnt_angle_prep: clamp of the angle and conversion to a binary angle, three stages
// depends on gnt_pkg
`timescale 1ns / 1ps

module gnt_angle_prep
  import gnt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic signed [ANGLE_W-1:0] up_angle,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output cordic_vec_t               dn_vec
);

  localparam logic signed [ANGLE_W-1:0] CLIP_POS = ANGLE_W'(CLIP_LIMIT_TENTHS);
  localparam logic signed [ANGLE_W-1:0] CLIP_NEG = -CLIP_POS;

  // stage 1: clamped magnitude and sign
  logic             v1_r, v1_nxt, rdy1;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic             neg1_r, neg1_nxt;

  // stage 2: table sums
  logic             v2_r, v2_nxt, rdy2;
  zmag_t            qsum_r, qsum_nxt;
  logic [R_W:0]     rsum_r, rsum_nxt;
  logic             neg2_r;

  // stage 3: signed binary angle
  logic             v3_r, v3_nxt, up3_ready;
  cordic_vec_t      vec_r, vec_nxt;

  logic [ANGLE_W-1:0] abs_angle;
  logic [R_W+1:0]     rnd_sum;
  logic [1:0]         carry;
  zmag_t              zmag;
  turn_ent_t          hi_ent, lo_ent;

  assign rdy1     = !v1_r || rdy2;
  assign rdy2     = !v2_r || up3_ready;
  assign up_ready = rdy1;
  assign dn_valid = v3_r;
  assign dn_vec   = vec_r;

  assign up3_ready = !v3_r || dn_ready;

  always_comb begin
    abs_angle = up_angle[ANGLE_W-1] ? ANGLE_W'(-up_angle) : ANGLE_W'(up_angle);
    neg1_nxt  = up_angle[ANGLE_W-1];
    if (up_angle > CLIP_POS || up_angle < CLIP_NEG) begin
      mag_nxt = MAG_W'(CLIP_LIMIT_TENTHS);
    end else begin
      mag_nxt = abs_angle[MAG_W-1:0];
    end
  end

  always_comb begin
    hi_ent   = HI_TAB[mag_r[MAG_W-1:LO_W]];
    lo_ent   = LO_TAB[mag_r[LO_W-1:0]];
    qsum_nxt = hi_ent.q + lo_ent.q;
    rsum_nxt = {1'b0, hi_ent.r} + {1'b0, lo_ent.r};
  end

  // remainders sum below three turns, so the rounding carry is 0, 1 or 2
  always_comb begin
    rnd_sum = {1'b0, rsum_r} + (R_W+2)'(TURN_HALF);
    priority if (rnd_sum >= (R_W+2)'(2 * TURN_DIV)) begin
      carry = 2'd2;
    end else if (rnd_sum >= (R_W+2)'(TURN_DIV)) begin
      carry = 2'd1;
    end else begin
      carry = 2'd0;
    end
    zmag      = qsum_r + ZM_W'(carry);
    vec_nxt.x = X_START;
    vec_nxt.y = '0;
    vec_nxt.z = neg2_r ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
  end

  assign v1_nxt = rdy1 ? up_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = up3_ready ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      mag_r  <= mag_nxt;
      neg1_r <= neg1_nxt;
    end
    if (rdy2 && v1_r) begin
      qsum_r <= qsum_nxt;
      rsum_r <= rsum_nxt;
      neg2_r <= neg1_r;
    end
    if (up3_ready && v2_r) begin
      vec_r <= vec_nxt;
    end
  end

endmodule

### src/gnt_cordic_cell.sv
// gnt_cordic_cell: one rotation step of the cordic chain with its own handshake
// depends on gnt_pkg
`timescale 1ns / 1ps

module gnt_cordic_cell
  import gnt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SHIFT_W-1:0] shift_amt,
  input  logic [Z_W-1:0]     atan_val,
  input  logic               up_valid,
  output logic               up_ready,
  input  cordic_vec_t        up_vec,
  output logic               dn_valid,
  input  logic               dn_ready,
  output cordic_vec_t        dn_vec
);

  logic        valid_r, valid_nxt;
  cordic_vec_t vec_r, vec_nxt;

  logic signed [XY_W-1:0] xs, ys;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_vec   = vec_r;

  // arithmetic shift gives the floor of a negative value
  always_comb begin
    xs = up_vec.x >>> shift_amt;
    ys = up_vec.y >>> shift_amt;
    if (!up_vec.z[Z_W-1]) begin
      vec_nxt.x = up_vec.x - ys;
      vec_nxt.y = up_vec.y + xs;
      vec_nxt.z = up_vec.z - $signed(atan_val);
    end else begin
      vec_nxt.x = up_vec.x + ys;
      vec_nxt.y = up_vec.y - xs;
      vec_nxt.z = up_vec.z + $signed(atan_val);
    end
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      vec_r <= vec_nxt;
    end
  end

endmodule

### src/gnt_tip_out.sv
// gnt_tip_out: radius scaling, rounding and centre offset, two stages
// depends on gnt_pkg
`timescale 1ns / 1ps

module gnt_tip_out
  import gnt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  tip_cfg_t                 cfg,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  cordic_vec_t              up_vec,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output logic signed [TIPX_W-1:0] dn_tip_x,
  output logic signed [TIPY_W-1:0] dn_tip_y
);

  // stage 1: magnitude products
  logic              v1_r, v1_nxt, rdy1, rdy2;
  logic [PROD_W-1:0] px_r, py_r;
  logic              nx_r, ny_r;

  // stage 2: output register
  logic                     v2_r, v2_nxt;
  logic signed [TIPX_W-1:0] tip_x_r, tip_x_nxt;
  logic signed [TIPY_W-1:0] tip_y_r, tip_y_nxt;

  logic [XY_W-1:0]         ax, ay;
  logic [PROD_W:0]         rx_full, ry_full;
  logic [RND_W-1:0]        rx, ry;
  logic signed [SUM_W-1:0] off_x, off_y, sum_x, sum_y;

  assign rdy1     = !v1_r || rdy2;
  assign rdy2     = !v2_r || dn_ready;
  assign up_ready = rdy1;
  assign dn_valid = v2_r;
  assign dn_tip_x = tip_x_r;
  assign dn_tip_y = tip_y_r;

  always_comb begin
    ax = up_vec.x[XY_W-1] ? XY_W'(-up_vec.x) : XY_W'(up_vec.x);
    ay = up_vec.y[XY_W-1] ? XY_W'(-up_vec.y) : XY_W'(up_vec.y);
  end

  // half away from zero on the magnitude, sign put back afterwards
  always_comb begin
    rx_full   = ({1'b0, py_r} + (PROD_W+1)'(1 << (TRIG_FRACTION_BITS - 1)))
                >> TRIG_FRACTION_BITS;
    ry_full   = ({1'b0, px_r} + (PROD_W+1)'(1 << (TRIG_FRACTION_BITS - 1)))
                >> TRIG_FRACTION_BITS;
    rx        = rx_full[RND_W-1:0];
    ry        = ry_full[RND_W-1:0];
    off_x     = ny_r ? -$signed(SUM_W'(rx)) : $signed(SUM_W'(rx));
    off_y     = nx_r ? -$signed(SUM_W'(ry)) : $signed(SUM_W'(ry));
    sum_x     = $signed(SUM_W'(cfg.centre_x)) + off_x;
    sum_y     = $signed(SUM_W'(cfg.centre_y)) - off_y;
    tip_x_nxt = sum_x[TIPX_W-1:0];
    tip_y_nxt = sum_y[TIPY_W-1:0];
  end

  assign v1_nxt = rdy1 ? up_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      px_r <= PROD_W'(ax) * PROD_W'(cfg.needle_radius);
      py_r <= PROD_W'(ay) * PROD_W'(cfg.needle_radius);
      nx_r <= up_vec.x[XY_W-1];
      ny_r <= up_vec.y[XY_W-1];
    end
    if (rdy2 && v1_r) begin
      tip_x_r <= tip_x_nxt;
      tip_y_r <= tip_y_nxt;
    end
  end

endmodule

### src/gauge_needle_tip_from_angle_top.sv
// gauge_needle_tip_from_angle_top: top level, configuration registers and the stage chain
// depends on gnt_pkg, gnt_angle_prep, gnt_cordic_cell and gnt_tip_out
`timescale 1ns / 1ps

// Turns a lean angle in tenths of a degree into the screen tip of a gauge needle.
// The angle is clamped to plus or minus 60.0 degrees, converted to a binary angle
// (2^32 units per turn) and rotated by a chain of 16 cordic cells, one iteration per
// cell; the tip is centre x plus radius times sine and centre y minus radius times
// cosine, each offset rounded half away from zero. Every stage is a register with
// its own valid bit and a ready that looks only at the next stage, so one angle is
// taken in every cycle while the result side keeps up, and bubbles close up when it
// stalls. The registers in order: one clamp stage, two angle conversion stages,
// one cell per cordic iteration, a multiply stage and the output register.
// The configuration port is always ready; centre and radius are meant to be written
// only while no transfer is in flight, and index 3 is ignored.

module gauge_needle_tip_from_angle_top
  import gnt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  // angle input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] in_angle_tenths,
  // tip result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [TIPX_W-1:0]  out_tip_x,
  output logic signed [TIPY_W-1:0]  out_tip_y
);

  // configuration registers
  tip_cfg_t cfg_r, cfg_nxt;

  // chain between stages: entry 0 from the angle prep, entry ITER_N into the output
  logic        chain_valid [ITER_N+1];
  logic        chain_ready [ITER_N+1];
  cordic_vec_t chain_vec   [ITER_N+1];

  assign cfg_ready = 1'b1;

  // only the register's own width is kept
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CENTRE_X:      cfg_nxt.centre_x      = cfg_data[CX_W-1:0];
        CFG_CENTRE_Y:      cfg_nxt.centre_y      = cfg_data[CY_W-1:0];
        CFG_NEEDLE_RADIUS: cfg_nxt.needle_radius = cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // clamp and binary angle conversion
  gnt_angle_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_angle (in_angle_tenths),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_vec   (chain_vec[0])
  );

  // one cell per cordic iteration, shift and arctangent fixed per position
  for (genvar i = 0; i < ITER_N; i++) begin : g_cell
    gnt_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_amt (SHIFT_W'(i)),
      .atan_val  (ATAN_TAB[i]),
      .up_valid  (chain_valid[i]),
      .up_ready  (chain_ready[i]),
      .up_vec    (chain_vec[i]),
      .dn_valid  (chain_valid[i+1]),
      .dn_ready  (chain_ready[i+1]),
      .dn_vec    (chain_vec[i+1])
    );
  end

  // scaling by the radius and offset from the centre
  gnt_tip_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (chain_valid[ITER_N]),
    .up_ready (chain_ready[ITER_N]),
    .up_vec   (chain_vec[ITER_N]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_tip_x (out_tip_x),
    .dn_tip_y (out_tip_y)
  );

endmodule

### tb/gnt_tip_checker.sv
// gnt_tip_checker: watches the register, angle and tip channels, predicts each tip and compares
// depends on gnt_pkg for port widths and register indexes
`timescale 1ns / 1ps

module gnt_tip_checker
  import gnt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] in_angle_tenths,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [TIPX_W-1:0]  out_tip_x,
  input  logic signed [TIPY_W-1:0]  out_tip_y,
  output int                        mismatches,
  output int                        expected_left,
  output int                        tips_checked
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [TIPX_W-1:0]  x;
    logic signed [TIPY_W-1:0]  y;
  } tip_t;

  localparam longint LEAN_LIMIT      = 600;
  localparam int     ROT_STEPS       = 16;
  localparam int     FRAC_BITS       = 16;
  localparam u64_t   TENTHS_PER_TURN = 3600;
  localparam u64_t   GAIN_Q32_WORD   = 64'h9B74EDA8;
  localparam int     PRINT_CAP       = 40;

  // unit vector pre-scaled by the inverse rotation gain
  localparam longint COS_START =
    longint'((GAIN_Q32_WORD + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  // atan(2^-i), 2^32 units per turn
  localparam longint ATAN_TURNS [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  logic [CX_W-1:0]  centre_x;
  logic [CY_W-1:0]  centre_y;
  logic [RAD_W-1:0] radius;
  tip_t             expected_tips [$];
  tip_t             want;

  // radius times a fraction, half away from zero
  function automatic longint round_scaled(input longint v, input u64_t rad);
    u64_t prod;
    u64_t rounded;
    prod    = (v < 0) ? -v : v;
    prod    = prod * rad;
    rounded = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (v < 0) ? -longint'(rounded) : longint'(rounded);
  endfunction

  function automatic tip_t predict_tip(input logic signed [ANGLE_W-1:0] angle_in);
    longint lean;
    longint resid;
    longint cos_acc;
    longint sin_acc;
    longint cos_sh;
    longint sin_sh;
    u64_t   turn_num;
    tip_t   tip;
    lean = angle_in;
    if (lean > LEAN_LIMIT) begin
      lean = LEAN_LIMIT;
    end else if (lean < -LEAN_LIMIT) begin
      lean = -LEAN_LIMIT;
    end
    turn_num = (lean < 0) ? -lean : lean;
    turn_num = (turn_num << 32) + TENTHS_PER_TURN / 2;
    resid    = turn_num / TENTHS_PER_TURN;
    if (lean < 0) begin
      resid = -resid;
    end
    cos_acc = COS_START;
    sin_acc = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      cos_sh = cos_acc >>> i;
      sin_sh = sin_acc >>> i;
      if (resid >= 0) begin
        cos_acc = cos_acc - sin_sh;
        sin_acc = sin_acc + cos_sh;
        resid   = resid - ATAN_TURNS[i];
      end else begin
        cos_acc = cos_acc + sin_sh;
        sin_acc = sin_acc - cos_sh;
        resid   = resid + ATAN_TURNS[i];
      end
    end
    tip.angle = angle_in;
    tip.x     = TIPX_W'(longint'(centre_x) + round_scaled(sin_acc, radius));
    tip.y     = TIPY_W'(longint'(centre_y) - round_scaled(cos_acc, radius));
    return tip;
  endfunction

  task automatic flag_tip(input string what, input longint got, input longint exp_val);
    if (mismatches < PRINT_CAP) begin
      $display("%0t ns tip check: %s got %0d want %0d", $time, what, got, exp_val);
    end
    mismatches++;
  endtask

  initial begin
    mismatches    = 0;
    expected_left = 0;
    tips_checked  = 0;
    centre_x      = '0;
    centre_y      = '0;
    radius        = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      centre_x = '0;
      centre_y = '0;
      radius   = '0;
      expected_tips.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CENTRE_X:      centre_x = cfg_data[CX_W-1:0];
          CFG_CENTRE_Y:      centre_y = cfg_data[CY_W-1:0];
          CFG_NEEDLE_RADIUS: radius   = cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_tips.push_back(predict_tip(in_angle_tenths));
      end
      if (out_valid && out_ready) begin
        if (expected_tips.size() == 0) begin
          flag_tip("tip with no angle outstanding, x", out_tip_x, 0);
        end else begin
          want = expected_tips.pop_front();
          tips_checked++;
          if (out_tip_x !== want.x) begin
            flag_tip($sformatf("tip_x for angle %0d", want.angle), out_tip_x, want.x);
          end
          if (out_tip_y !== want.y) begin
            flag_tip($sformatf("tip_y for angle %0d", want.angle), out_tip_y, want.y);
          end
        end
      end
    end
    expected_left = expected_tips.size();
  end

endmodule

### tb/gauge_needle_tip_from_angle_top_tb.sv
// gauge_needle_tip_from_angle_top_tb: stimulus, clock, reset and verdict for the needle tip block
// depends on gnt_pkg, gauge_needle_tip_from_angle_top and gnt_tip_checker
`timescale 1ns / 1ps

module gauge_needle_tip_from_angle_top_tb;
  import gnt_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 8;
  // clamp, two conversion stages, one cell per iteration, multiply, output register
  localparam int PIPE_LATENCY     = TRIG_FRACTION_BITS + 5;
  localparam int SETTLE_CYCLES    = PIPE_LATENCY + 10;
  localparam int TIMEOUT_NS       = 4_000_000;
  localparam int HALF_PHASE_ITEMS = 190;
  // index past the register list, the block should drop the write
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // corners of the angle field: zero, clip edges either side, wrap extremes,
  // and magnitudes that straddle the split of the angle into high and low parts
  localparam logic signed [ANGLE_W-1:0] CORNER_ANGLES [22] = '{
    0, 1, -1, 599, -599, 600, -600, 601, -601, 900, -900,
    32767, -32768, 450, -450, 300, -300, 15, 16, -16, 255, 256
  };

  logic                      clk             = 1'b0;
  logic                      rst_n           = 1'b0;
  logic                      cfg_valid       = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index       = CFG_CENTRE_X;
  logic [CFG_DATA_W-1:0]     cfg_data        = '0;
  logic                      in_valid        = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] in_angle_tenths = '0;
  logic                      out_valid;
  logic                      out_ready       = 1'b0;
  logic signed [TIPX_W-1:0]  out_tip_x;
  logic signed [TIPY_W-1:0]  out_tip_y;

  // idle chances in percent, per cycle
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int angles_sent   = 0;
  int reg_writes    = 0;
  int mismatches;
  int expected_left;
  int tips_checked;

  gauge_needle_tip_from_angle_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_angle_tenths (in_angle_tenths),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tip_x       (out_tip_x),
    .out_tip_y       (out_tip_y)
  );

  gnt_tip_checker tip_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_angle_tenths (in_angle_tenths),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tip_x       (out_tip_x),
    .out_tip_y       (out_tip_y),
    .mismatches      (mismatches),
    .expected_left   (expected_left),
    .tips_checked    (tips_checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one angle transfer; valid stays up between back-to-back angles and only
  // drops while the sender idles, so the payload never moves under a held valid
  task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_angle_tenths <= angle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    angles_sent++;
  endtask

  // mostly inside the working span, some around the clip edges, some anywhere
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int mag;
    case ($urandom_range(9))
      0, 1: return ANGLE_W'($urandom());
      2: begin
        mag = CLIP_LIMIT_TENTHS - 10 + int'($urandom_range(20));
        return ANGLE_W'($urandom_range(1) ? mag : -mag);
      end
      default: return ANGLE_W'(int'($urandom_range(1400)) - 700);
    endcase
  endfunction

  task automatic send_random_angles(input int count);
    repeat (count) send_angle(random_angle());
  endtask

  // one register transfer, valid left up for a following write
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  // full needle setting; radius is given as the raw 10-bit word so the top bit
  // can be set and must be dropped; optionally pokes the unused index on the way
  task automatic program_needle(input logic [CFG_DATA_W-1:0] cx,
                                input logic [CFG_DATA_W-1:0] cy,
                                input logic [CFG_DATA_W-1:0] rad_word,
                                input bit                    poke_spare);
    put_reg(CFG_CENTRE_X, cx);
    put_reg(CFG_CENTRE_Y, cy);
    if (poke_spare) begin
      put_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
    end
    put_reg(CFG_NEEDLE_RADIUS, rad_word);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every tip in flight has come out; sampled on the
  // falling edge so the checker's count for this cycle has settled
  task automatic wait_tips_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_left != 0);
    @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at reset: zero radius and centre pin every tip to the origin
    send_angle(0);
    send_angle(CLIP_LIMIT_TENTHS);
    send_angle(-32768);
    wait_tips_drained();

    // largest centre and radius over the corner angles, sender idles 30, receiver 52
    send_idle_pct = 30;
    recv_idle_pct <= 52;
    program_needle(10'd1023, 10'd1023, 10'd511, 1'b0);
    foreach (CORNER_ANGLES[i]) send_angle(CORNER_ANGLES[i]);
    wait_tips_drained();

    // random setting with a stray write to the unused index, and one full
    // stop of the sender half way through
    program_needle(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                   CFG_DATA_W'($urandom()), 1'b1);
    send_random_angles(HALF_PHASE_ITEMS);
    wait_tips_drained();
    send_random_angles(HALF_PHASE_ITEMS);
    wait_tips_drained();

    // stall pattern swapped; centre at the origin and an all-ones radius word
    send_idle_pct = 52;
    recv_idle_pct <= 30;
    program_needle(10'd0, 10'd0, 10'h3FF, 1'b1);
    send_random_angles(2 * HALF_PHASE_ITEMS);
    wait_tips_drained();

    // no idling on either side, two more settings
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    program_needle(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                   CFG_DATA_W'($urandom()), 1'b0);
    send_random_angles(HALF_PHASE_ITEMS + 5);
    wait_tips_drained();
    // radius word with only the dropped bit and bit 0 set leaves a radius of one
    program_needle(10'd512, 10'd0, 10'h201, 1'b1);
    send_random_angles(HALF_PHASE_ITEMS + 5);
    wait_tips_drained();

    // let anything stray fall out of the pipe before judging
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d angles sent, %0d tips compared, %0d register transfers,",
             angles_sent, tips_checked, reg_writes);
    $display("summary: corner angles, clip edges, full-range wrap, three stall patterns");
    if (mismatches == 0 && expected_left == 0) begin
      $display("gauge_needle_tip_from_angle_top_tb passed");
    end else begin
      if (expected_left != 0) begin
        $display("%0d tips never arrived", expected_left);
      end
      $display("gauge_needle_tip_from_angle_top_tb failed");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("run timed out with %0d tips outstanding", expected_left);
    $display("gauge_needle_tip_from_angle_top_tb failed");
    $finish;
  end

endmodule

### gauge_needle_tip_from_angle_top.f
src/gnt_pkg.sv
src/gnt_angle_prep.sv
src/gnt_cordic_cell.sv
src/gnt_tip_out.sv
src/gauge_needle_tip_from_angle_top.sv
tb/gnt_tip_checker.sv
tb/gauge_needle_tip_from_angle_top_tb.sv
